// ===== rtl/fpba_pkg.sv =====
// shared constants, codes and widths for the fit policy block allocator
package fpba_pkg;

    // table geometry
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    // fixed field widths
    localparam int AMT_W    = 16;
    localparam int BLK_W    = 4;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // derived widths
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd2;

    // placement policies, any other code acts as first fit
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

endpackage

// ===== rtl/fit_policy_block_allocator.sv =====
// fit policy block allocator: free space table with a one-block-per-cycle scan
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | into      | in_valid/in_ready   | req_type, block_index, amount
//  out     | out of    | out_valid/out_ready | status, granted_block, space_left
//  cfg     | into      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a load request goes from idle straight to finish; an allocate request scans
// n entries, n being block_count clipped to MAX_BLOCKS, reading one table entry
// and running one compare each cycle. the result sits in an output register, so
// a new request is taken while the previous result waits; a finished request
// holds until that register is free. cfg_ready is always high. reset clears
// the table, both registers, state, out_valid, found flag and scan pointer.
module fit_policy_block_allocator
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [fpba_pkg::BLK_W-1:0]         block_index,
    input  logic [fpba_pkg::AMT_W-1:0]         amount,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fpba_pkg::STATUS_W-1:0]      status,
    output logic [fpba_pkg::BLK_W-1:0]         granted_block,
    output logic [fpba_pkg::AMT_W-1:0]         space_left,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SB  = fpba_pkg::SIZE_BITS;
    localparam int IW  = fpba_pkg::IDX_W;
    localparam int CW  = fpba_pkg::CNT_W;
    localparam int MW  = fpba_pkg::CMP_W;
    localparam int AW  = fpba_pkg::AMT_W;
    localparam int BW  = fpba_pkg::BLK_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

    state_t                          state_reg;
    logic [SB-1:0]                   table_reg [fpba_pkg::MAX_BLOCKS];
    logic [fpba_pkg::MODE_W-1:0]     mode_reg;
    logic [fpba_pkg::COUNT_W-1:0]    count_reg;
    logic                            kind_reg;
    logic [BW-1:0]                   blk_reg;
    logic [AW-1:0]                   amt_reg;
    logic [IW-1:0]                   cnt_reg;
    logic [CW-1:0]                   n_reg;
    logic                            found_reg;
    logic [IW-1:0]                   pick_reg;
    logic [SB-1:0]                   best_reg;
    logic                            out_valid_reg;
    logic [fpba_pkg::STATUS_W-1:0]   status_reg;
    logic [BW-1:0]                   granted_reg;
    logic [AW-1:0]                   left_reg;

    logic                            load_in_range;
    logic [CW-1:0]                   n_clip;
    logic [SB-1:0]                   cur_space;
    logic                            fits;
    logic                            better;
    logic                            take;
    logic                            last;
    logic                            out_free;
    logic [MW-1:0]                   diff;
    logic [SB-1:0]                   new_space;

    // handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // request decode
    assign load_in_range = (32'(block_index) < fpba_pkg::MAX_BLOCKS);
    assign n_clip = (32'(count_reg) > fpba_pkg::MAX_BLOCKS) ?
                    CW'(fpba_pkg::MAX_BLOCKS) : CW'(count_reg);

    // shared compare unit on the entry under the scan pointer
    assign cur_space = table_reg[cnt_reg];
    assign fits      = (MW'(cur_space) >= MW'(amt_reg));
    always_comb
    begin
        case (mode_reg)
            fpba_pkg::MODE_BEST:  better = (cur_space < best_reg);
            fpba_pkg::MODE_WORST: better = (cur_space > best_reg);
            default:              better = 1'b0;
        endcase
    end
    assign take = fits && (!found_reg || better);
    assign last = ((CW'(cnt_reg) + CW'(1)) == n_reg);

    // update of the chosen block
    assign diff      = MW'(best_reg) - MW'(amt_reg);
    assign new_space = SB'(diff);

    // sequencer, table and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            for (int i = 0; i < fpba_pkg::MAX_BLOCKS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fpba_pkg::CFG_FIT_MODE)
                begin
                    mode_reg <= cfg_data[fpba_pkg::MODE_W-1:0];
                end
                else if (cfg_index == fpba_pkg::CFG_BLOCK_COUNT)
                begin
                    count_reg <= cfg_data[fpba_pkg::COUNT_W-1:0];
                end
            end

            // result taken downstream
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg  <= req_type;
                        blk_reg   <= block_index;
                        amt_reg   <= amount;
                        n_reg     <= n_clip;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        pick_reg  <= '0;
                        best_reg  <= '0;
                        if (req_type == fpba_pkg::REQ_LOAD)
                        begin
                            if (load_in_range)
                            begin
                                table_reg[IW'(block_index)] <= SB'(amount);
                            end
                            state_reg <= S_FINISH;
                        end
                        else if (n_clip == '0)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                // one block per cycle
                S_SCAN:
                begin
                    if (take)
                    begin
                        found_reg <= 1'b1;
                        pick_reg  <= cnt_reg;
                        best_reg  <= cur_space;
                    end
                    if (last)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + IW'(1);
                    end
                end

                // write back and hand the result over
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (kind_reg == fpba_pkg::REQ_LOAD)
                        begin
                            status_reg  <= fpba_pkg::ST_LOADED;
                            granted_reg <= blk_reg;
                            left_reg    <= (32'(blk_reg) < fpba_pkg::MAX_BLOCKS) ?
                                           AW'(MW'(SB'(amt_reg))) : '0;
                        end
                        else if (found_reg)
                        begin
                            table_reg[pick_reg] <= new_space;
                            status_reg  <= fpba_pkg::ST_ALLOCATED;
                            granted_reg <= BW'(pick_reg);
                            left_reg    <= AW'(MW'(new_space));
                        end
                        else
                        begin
                            status_reg  <= fpba_pkg::ST_NO_FIT;
                            granted_reg <= '0;
                            left_reg    <= '0;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // outputs
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_block = granted_reg;
    assign space_left    = left_reg;

endmodule

// ===== rtl/fpba_checker.sv =====
// port level checks for the fit policy block allocator
module fpba_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [fpba_pkg::STATUS_W-1:0]      status,
    input  logic [fpba_pkg::BLK_W-1:0]         granted_block,
    input  logic [fpba_pkg::AMT_W-1:0]         space_left
);

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(granted_block) && $stable(space_left))
        else $error("stalled result changed");

    // a result only goes away once taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without handshake");

    // a rejected request reports no block and no space
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fpba_pkg::ST_NO_FIT |->
            granted_block == '0 && space_left == '0)
        else $error("rejected request carries block data");

    // the block is busy in the cycle after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_block (granted_block),
    .space_left    (space_left)
);
